FILE: hdl/rmq_pkg.sv
package rmq_pkg;

	localparam int IN_W          = 18;
	localparam int OUT_W         = 18;
	// sum or difference of two matrix elements
	localparam int TERM_W        = IN_W + 1;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	// which quaternion component comes from the half root
	typedef enum logic [1:0] {
		BR_X = 2'd0,
		BR_Y = 2'd1,
		BR_Z = 2'd2,
		BR_W = 2'd3
	} branch_t;

	// the three off-diagonal terms in ascending component order, skipping the branch one
	typedef struct packed {
		logic                     err;
		branch_t                  br;
		logic signed [TERM_W-1:0] n0;
		logic signed [TERM_W-1:0] n1;
		logic signed [TERM_W-1:0] n2;
	} cls_t;

endpackage

FILE: hdl/rmq_fifo.sv
module rmq_fifo import rmq_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic         empty,
	output logic [W-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr_en, rd_en;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wdata;
	end

endmodule

FILE: hdl/rmq_front.sv
module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int AW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2,
	localparam int AUW = AW - 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_push,
	output logic                   in_full,
	input  logic signed [IN_W-1:0] m00,
	input  logic signed [IN_W-1:0] m01,
	input  logic signed [IN_W-1:0] m02,
	input  logic signed [IN_W-1:0] m10,
	input  logic signed [IN_W-1:0] m11,
	input  logic signed [IN_W-1:0] m12,
	input  logic signed [IN_W-1:0] m20,
	input  logic signed [IN_W-1:0] m21,
	input  logic signed [IN_W-1:0] m22,
	output logic                   o_valid,
	input  logic                   o_ready,
	output cls_t                   o_cls,
	output logic [AUW-1:0]         o_arg
);

	localparam logic signed [AW-1:0] ONE_A = AW'(1) <<< FRAC_BITS;

	logic signed [AW-1:0]     e00, e11, e22, tr, arg;
	logic signed [TERM_W-1:0] s12, s20, s01, p01, p02, p12;
	branch_t                  br;
	cls_t                     cls;
	logic [AUW-1:0]           arg_u;

	logic           v_s1;
	cls_t           cls_s1;
	logic [AUW-1:0] arg_s1;

	always_comb begin
		e00 = AW'(m00);
		e11 = AW'(m11);
		e22 = AW'(m22);
		tr  = e00 + e11 + e22;
		priority if (tr > 0) begin
			br  = BR_W;
			arg = ONE_A + tr;
		end else if (e00 > e11 && e00 > e22) begin
			br  = BR_X;
			arg = ONE_A + (e00 - (e11 + e22));
		end else if (e11 > e22) begin
			br  = BR_Y;
			arg = ONE_A + (e11 - (e22 + e00));
		end else begin
			br  = BR_Z;
			arg = ONE_A + (e22 - (e00 + e11));
		end

		s12 = TERM_W'(m12) - TERM_W'(m21);
		s20 = TERM_W'(m20) - TERM_W'(m02);
		s01 = TERM_W'(m01) - TERM_W'(m10);
		p01 = TERM_W'(m01) + TERM_W'(m10);
		p02 = TERM_W'(m20) + TERM_W'(m02);
		p12 = TERM_W'(m12) + TERM_W'(m21);

		cls.br = br;
		unique case (br)
			BR_W: begin cls.n0 = s12; cls.n1 = s20; cls.n2 = s01; end
			BR_X: begin cls.n0 = p01; cls.n1 = p02; cls.n2 = s12; end
			BR_Y: begin cls.n0 = p01; cls.n1 = p12; cls.n2 = s20; end
			BR_Z: begin cls.n0 = p02; cls.n1 = p12; cls.n2 = s01; end
			default: begin cls.n0 = s12; cls.n1 = s20; cls.n2 = s01; end
		endcase

		// a bad argument still goes down as one so the divisor stays nonzero
		cls.err = (arg <= 0);
		arg_u   = cls.err ? AUW'(1) : arg[AUW-1:0];
	end

	assign in_full = v_s1 && !o_ready;
	assign o_valid = v_s1;
	assign o_cls   = cls_s1;
	assign o_arg   = arg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (!in_full)
			v_s1 <= in_push;
	end

	always_ff @(posedge clk) begin
		if (!in_full && in_push) begin
			cls_s1 <= cls;
			arg_s1 <= arg_u;
		end
	end

endmodule

FILE: hdl/rmq_back.sv
module rmq_back import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int AW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2,
	localparam int AUW = AW - 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    i_valid,
	output logic                    i_ready,
	input  cls_t                    i_cls,
	input  logic [AUW-1:0]          i_arg,
	output logic                    o_valid,
	input  logic                    o_ready,
	output logic signed [OUT_W-1:0] quat_x,
	output logic signed [OUT_W-1:0] quat_y,
	output logic signed [OUT_W-1:0] quat_z,
	output logic signed [OUT_W-1:0] quat_w,
	output logic                    root_error
);

	localparam int XW  = AUW + FRAC_BITS;
	localparam int XWE = XW + (XW % 2);
	localparam int SRW = XWE / 2;
	localparam int RMW = SRW + 2;
	localparam int NW  = TERM_W + FRAC_BITS + 1;
	localparam int DRW = SRW + 2;
	localparam int VW  = (FRAC_BITS + 2 > OUT_W) ? FRAC_BITS + 2 : OUT_W;
	localparam logic [NW-1:0]  ONE_N = NW'(1) << FRAC_BITS;
	localparam logic [SRW-1:0] ONE_H = SRW'(1) << FRAC_BITS;

	logic en;

	// root stages, two radicand bits each
	logic           sq_v_q    [1:SRW];
	logic [XWE-1:0] sq_x_q    [1:SRW];
	logic [RMW-1:0] sq_rem_q  [1:SRW];
	logic [SRW-1:0] sq_root_q [1:SRW];
	cls_t           sq_cls_q  [1:SRW];

	// setup of numerators and divisor
	logic           su_v_q;
	logic [NW-1:0]  su_n_q    [3];
	logic [2:0]     su_neg_q;
	logic [SRW:0]   su_d_q;
	logic [SRW-1:0] su_half_q;
	cls_t           su_cls_q;

	// divider stages, one quotient bit each, three lanes
	logic           dv_v_q    [1:NW];
	logic [NW-1:0]  dv_nq_q   [1:NW][3];
	logic [DRW-1:0] dv_rem_q  [1:NW][3];
	logic [2:0]     dv_neg_q  [1:NW];
	logic [SRW:0]   dv_d_q    [1:NW];
	logic [SRW-1:0] dv_half_q [1:NW];
	cls_t           dv_cls_q  [1:NW];

	logic                    fin_v_q;
	logic signed [OUT_W-1:0] fx_q, fy_q, fz_q, fw_q;
	logic                    ferr_q;

	assign en      = !fin_v_q || o_ready;
	assign i_ready = en;

	for (genvar k = 1; k <= SRW; k++) begin : g_sq
		logic           pv;
		logic [XWE-1:0] px;
		logic [RMW-1:0] prem, t, trial;
		logic [SRW-1:0] proot;
		cls_t           pcls;
		logic           ge;

		if (k == 1) begin : g_src
			assign pv    = i_valid;
			assign px    = XWE'(i_arg) << FRAC_BITS;
			assign prem  = '0;
			assign proot = '0;
			assign pcls  = i_cls;
		end else begin : g_src
			assign pv    = sq_v_q[k-1];
			assign px    = sq_x_q[k-1];
			assign prem  = sq_rem_q[k-1];
			assign proot = sq_root_q[k-1];
			assign pcls  = sq_cls_q[k-1];
		end

		assign t     = {prem[SRW-1:0], px[XWE-1 -: 2]};
		assign trial = {proot, 2'b01};
		assign ge    = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_q[k] <= 1'b0;
			else if (en)
				sq_v_q[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x_q[k]    <= px << 2;
				sq_rem_q[k]  <= ge ? t - trial : t;
				sq_root_q[k] <= {proot[SRW-2:0], ge};
				sq_cls_q[k]  <= pcls;
			end
		end
	end

	logic [SRW-1:0]           sr;
	logic signed [TERM_W-1:0] lane_n [3];
	logic [TERM_W-1:0]        lane_mag [3];

	always_comb begin
		sr        = sq_root_q[SRW];
		lane_n[0] = sq_cls_q[SRW].n0;
		lane_n[1] = sq_cls_q[SRW].n1;
		lane_n[2] = sq_cls_q[SRW].n2;
		for (int j = 0; j < 3; j++)
			lane_mag[j] = lane_n[j][TERM_W-1] ? TERM_W'(-lane_n[j]) : TERM_W'(lane_n[j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			su_v_q <= 1'b0;
		else if (en)
			su_v_q <= sq_v_q[SRW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				// round half up: (mag * one + sr) / (2 * sr)
				su_n_q[j]   <= (NW'(lane_mag[j]) << FRAC_BITS) + NW'(sr);
				su_neg_q[j] <= lane_n[j][TERM_W-1];
			end
			su_d_q    <= {sr, 1'b0};
			su_half_q <= sr >> 1;
			su_cls_q  <= sq_cls_q[SRW];
		end
	end

	for (genvar k = 1; k <= NW; k++) begin : g_dv
		logic           pv;
		logic [NW-1:0]  pnq  [3];
		logic [DRW-1:0] prem [3];
		logic [DRW-1:0] t    [3];
		logic [2:0]     pneg;
		logic [SRW:0]   pd;
		logic [SRW-1:0] phalf;
		cls_t           pcls;
		logic [2:0]     ge;

		if (k == 1) begin : g_src
			assign pv    = su_v_q;
			assign pnq   = su_n_q;
			assign prem  = '{default: '0};
			assign pneg  = su_neg_q;
			assign pd    = su_d_q;
			assign phalf = su_half_q;
			assign pcls  = su_cls_q;
		end else begin : g_src
			assign pv    = dv_v_q[k-1];
			assign pnq   = dv_nq_q[k-1];
			assign prem  = dv_rem_q[k-1];
			assign pneg  = dv_neg_q[k-1];
			assign pd    = dv_d_q[k-1];
			assign phalf = dv_half_q[k-1];
			assign pcls  = dv_cls_q[k-1];
		end

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				t[j]  = {prem[j][DRW-2:0], pnq[j][NW-1]};
				ge[j] = (t[j] >= DRW'(pd));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_q[k] <= 1'b0;
			else if (en)
				dv_v_q[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					dv_nq_q[k][j]  <= {pnq[j][NW-2:0], ge[j]};
					dv_rem_q[k][j] <= ge[j] ? t[j] - DRW'(pd) : t[j];
				end
				dv_neg_q[k]  <= pneg;
				dv_d_q[k]    <= pd;
				dv_half_q[k] <= phalf;
				dv_cls_q[k]  <= pcls;
			end
		end
	end

	logic [FRAC_BITS:0]      mag_l [3];
	logic [FRAC_BITS:0]      mag_h;
	logic signed [VW-1:0]    val_l [3];
	logic signed [VW-1:0]    val_h;
	logic signed [OUT_W-1:0] l0, l1, l2, hv;
	logic signed [OUT_W-1:0] nx, ny, nz, nw;
	cls_t                    fcls;

	always_comb begin
		fcls = dv_cls_q[NW];
		for (int j = 0; j < 3; j++) begin
			mag_l[j] = (dv_nq_q[NW][j] > ONE_N) ? ONE_N[FRAC_BITS:0]
			                                    : dv_nq_q[NW][j][FRAC_BITS:0];
			val_l[j] = dv_neg_q[NW][j] ? -VW'(mag_l[j]) : VW'(mag_l[j]);
		end
		mag_h = (dv_half_q[NW] > ONE_H) ? ONE_H[FRAC_BITS:0] : dv_half_q[NW][FRAC_BITS:0];
		val_h = VW'(mag_h);
		l0 = val_l[0][OUT_W-1:0];
		l1 = val_l[1][OUT_W-1:0];
		l2 = val_l[2][OUT_W-1:0];
		hv = val_h[OUT_W-1:0];
		unique case (fcls.br)
			BR_W: begin nx = l0; ny = l1; nz = l2; nw = hv; end
			BR_X: begin nx = hv; ny = l0; nz = l1; nw = l2; end
			BR_Y: begin nx = l0; ny = hv; nz = l1; nw = l2; end
			BR_Z: begin nx = l0; ny = l1; nz = hv; nw = l2; end
			default: begin nx = l0; ny = l1; nz = l2; nw = hv; end
		endcase
		if (fcls.err) begin
			nx = '0;
			ny = '0;
			nz = '0;
			nw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fin_v_q <= 1'b0;
		else if (en)
			fin_v_q <= dv_v_q[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_q   <= nx;
			fy_q   <= ny;
			fz_q   <= nz;
			fw_q   <= nw;
			ferr_q <= fcls.err;
		end
	end

	assign o_valid    = fin_v_q;
	assign quat_x     = fx_q;
	assign quat_y     = fy_q;
	assign quat_z     = fz_q;
	assign quat_w     = fw_q;
	assign root_error = ferr_q;

endmodule

FILE: hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion (branch method), scalar part last, signed fixed point with
// FRAC_BITS fraction bits, every component saturated to [-1, +1]. A front stage classifies
// each matrix (trace or largest diagonal) and forms the root argument and the three
// off-diagonal terms; a two-item queue feeds the back pipeline, which takes the root two
// radicand bits per stage and then divides the three terms in parallel lanes, one quotient
// bit per stage. One item is taken per cycle when results are popped as they appear. An item
// passes the front register, the queue, S = ceil((max(FRAC_BITS,19) + 1 + FRAC_BITS) / 2) root
// stages, a setup register, N = FRAC_BITS + 20 divider stages and a final register before it
// reaches the output queue; the divider chain is the longer part. A root argument
// that is not positive gives root_error high and all four components zero.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [IN_W-1:0]  m00,
	input  logic signed [IN_W-1:0]  m01,
	input  logic signed [IN_W-1:0]  m02,
	input  logic signed [IN_W-1:0]  m10,
	input  logic signed [IN_W-1:0]  m11,
	input  logic signed [IN_W-1:0]  m12,
	input  logic signed [IN_W-1:0]  m20,
	input  logic signed [IN_W-1:0]  m21,
	input  logic signed [IN_W-1:0]  m22,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [OUT_W-1:0] quat_x,
	output logic signed [OUT_W-1:0] quat_y,
	output logic signed [OUT_W-1:0] quat_z,
	output logic signed [OUT_W-1:0] quat_w,
	output logic                    root_error
);

	localparam int AW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
	localparam int AUW = AW - 1;
	localparam int QW  = $bits(cls_t) + AUW;
	localparam int RW  = 4 * OUT_W + 1;

	logic           f_valid, q_full, q_empty, b_ready;
	cls_t           f_cls, b_cls;
	logic [AUW-1:0] f_arg, b_arg;
	logic [QW-1:0]  q_rdata;

	logic                    b_valid, o_full;
	logic signed [OUT_W-1:0] bx, by, bz, bw;
	logic                    berr;
	logic [RW-1:0]           o_rdata;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (push),
		.in_full (full),
		.m00     (m00),
		.m01     (m01),
		.m02     (m02),
		.m10     (m10),
		.m11     (m11),
		.m12     (m12),
		.m20     (m20),
		.m21     (m21),
		.m22     (m22),
		.o_valid (f_valid),
		.o_ready (!q_full),
		.o_cls   (f_cls),
		.o_arg   (f_arg)
	);

	rmq_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_valid),
		.full   (q_full),
		.wdata  ({f_cls, f_arg}),
		.rd     (b_ready),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign {b_cls, b_arg} = q_rdata;

	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.i_valid    (!q_empty),
		.i_ready    (b_ready),
		.i_cls      (b_cls),
		.i_arg      (b_arg),
		.o_valid    (b_valid),
		.o_ready    (!o_full),
		.quat_x     (bx),
		.quat_y     (by),
		.quat_z     (bz),
		.quat_w     (bw),
		.root_error (berr)
	);

	rmq_fifo #(.W(RW), .DEPTH(QUEUE_DEPTH)) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (b_valid),
		.full   (o_full),
		.wdata  ({bx, by, bz, bw, berr}),
		.rd     (pop),
		.empty  (empty),
		.rdata  (o_rdata)
	);

	assign {quat_x, quat_y, quat_z, quat_w, root_error} = o_rdata;

endmodule

FILE: hdl/rmq_chk.sv
module rmq_chk import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    empty,
	input logic                    pop,
	input logic signed [OUT_W-1:0] quat_x,
	input logic signed [OUT_W-1:0] quat_y,
	input logic signed [OUT_W-1:0] quat_z,
	input logic signed [OUT_W-1:0] quat_w,
	input logic                    root_error
);

	// a waiting item holds still until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(quat_x) && $stable(quat_y)
		&& $stable(quat_z) && $stable(quat_w) && $stable(root_error))
		else $error("waiting item changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && root_error |-> quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
		else $error("error item with nonzero components");

	// the half-root component is never negative, so the four components are never all negative
	a_half_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(FRAC_BITS <= OUT_W - 2) && !empty && !root_error
		|-> !(quat_x[OUT_W-1] && quat_y[OUT_W-1] && quat_z[OUT_W-1] && quat_w[OUT_W-1]))
		else $error("all components negative");

endmodule

bind rotation_matrix_to_quaternion rmq_chk #(.FRAC_BITS(FRAC_BITS)) u_rmq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.quat_x     (quat_x),
	.quat_y     (quat_y),
	.quat_z     (quat_z),
	.quat_w     (quat_w),
	.root_error (root_error)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rmq_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
		logic signed [OUT_W-1:0] w;
		logic                    err;
	} quat_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic empty;
	logic pop;
	logic signed [OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;
	logic root_error;

	quat_t expected_quats[$];
	int mismatches;
	int idle_cycles;
	int pop_mode;

	rotation_matrix_to_quaternion dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22), .empty(empty), .pop(pop),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.root_error(root_error)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_unit(longint v);
		longint u;
		u = longint'(1) << FB;
		if (v > u)
			return u;
		if (v < -u)
			return -u;
		return v;
	endfunction

	// |n| / (2 root), rounded half away from zero
	function automatic logic signed [OUT_W-1:0] scaled_term(longint n, longint unsigned sr);
		longint unsigned mag;
		longint q;
		mag = (n < 0) ? longint'(-n) : n;
		q = longint'(((mag << FB) + sr) / (2 * sr));
		return OUT_W'(clamp_unit((n < 0) ? -q : q));
	endfunction

	function automatic quat_t matrix_to_quat(longint a00, longint a01, longint a02,
			longint a10, longint a11, longint a12, longint a20, longint a21, longint a22);
		quat_t r;
		longint u;
		longint tr;
		longint arg;
		branch_t br;
		longint unsigned sr;
		logic signed [OUT_W-1:0] half;
		u = longint'(1) << FB;
		tr = a00 + a11 + a22;
		if (tr > 0) begin
			br = BR_W;
			arg = u + tr;
		end else if (a00 > a11 && a00 > a22) begin
			br = BR_X;
			arg = u + a00 - a11 - a22;
		end else if (a11 > a22) begin
			br = BR_Y;
			arg = u + a11 - a22 - a00;
		end else begin
			br = BR_Z;
			arg = u + a22 - a00 - a11;
		end
		r = '{x: '0, y: '0, z: '0, w: '0, err: 1'b0};
		if (arg <= 0) begin
			r.err = 1'b1;
			return r;
		end
		sr = int_sqrt(longint'(arg) << FB);
		half = OUT_W'(clamp_unit(longint'(int_sqrt(longint'(arg) << (FB - 2)))));
		case (br)
			BR_W: begin
				r.x = scaled_term(a12 - a21, sr);
				r.y = scaled_term(a20 - a02, sr);
				r.z = scaled_term(a01 - a10, sr);
				r.w = half;
			end
			BR_X: begin
				r.x = half;
				r.y = scaled_term(a01 + a10, sr);
				r.z = scaled_term(a20 + a02, sr);
				r.w = scaled_term(a12 - a21, sr);
			end
			BR_Y: begin
				r.x = scaled_term(a10 + a01, sr);
				r.y = half;
				r.z = scaled_term(a12 + a21, sr);
				r.w = scaled_term(a20 - a02, sr);
			end
			default: begin
				r.x = scaled_term(a20 + a02, sr);
				r.y = scaled_term(a12 + a21, sr);
				r.z = half;
				r.w = scaled_term(a01 - a10, sr);
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic signed [OUT_W-1:0] got,
			logic signed [OUT_W-1:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// send one matrix; sender bursts are shaped by the callers
	task automatic send_matrix(logic signed [IN_W-1:0] e[9]);
		push <= 1'b1;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		expected_quats.push_back(matrix_to_quat(e[0], e[1], e[2], e[3], e[4], e[5],
			e[6], e[7], e[8]));
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic pause_sender(int cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic random_gap();
		if ($urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 6));
	endtask

	function automatic logic signed [IN_W-1:0] random_elem(int mode);
		case (mode)
			0: return IN_W'($urandom);
			1: return IN_W'($signed($urandom_range(0, 131072)) - 65536);
			default: return IN_W'($signed($urandom_range(0, 4096)) - 2048);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [IN_W-1:0] e[9];
		logic signed [IN_W-1:0] one, mone, maxv, minv;
		one = 18'sd65536;
		mone = -18'sd65536;
		maxv = 18'sh1ffff;
		minv = 18'sh20000;
		e = '{one, 0, 0, 0, one, 0, 0, 0, one};
		send_matrix(e);
		// 180 degree turns exercise every diagonal branch
		e = '{one, 0, 0, 0, mone, 0, 0, 0, mone};
		send_matrix(e);
		e = '{mone, 0, 0, 0, one, 0, 0, 0, mone};
		send_matrix(e);
		e = '{mone, 0, 0, 0, mone, 0, 0, 0, one};
		send_matrix(e);
		// trace exactly zero and diagonal ties
		e = '{0, one, 0, mone, 0, 0, 0, 0, 0};
		send_matrix(e);
		e = '{0, 5, 7, 9, 0, 11, 13, 17, 0};
		send_matrix(e);
		e = '{100, 3, 4, 5, 100, 6, 7, 8, -200};
		send_matrix(e);
		e = '{-100, 3, 4, 5, 50, 6, 7, 8, 50};
		send_matrix(e);
		// negative and full-scale diagonals
		e = '{mone, 1, 2, 3, mone, 4, 5, 6, mone};
		send_matrix(e);
		e = '{minv, maxv, minv, maxv, minv, maxv, minv, maxv, minv};
		send_matrix(e);
		e = '{maxv, maxv, minv, minv, maxv, minv, maxv, minv, maxv};
		send_matrix(e);
		e = '{minv, minv, maxv, maxv, minv, minv, minv, maxv, maxv};
		send_matrix(e);
		// full-scale off-diagonals and saturated components
		e = '{-65535, maxv, minv, minv, -65535, maxv, maxv, minv, 65535};
		send_matrix(e);
		e = '{0, maxv, maxv, maxv, 0, maxv, maxv, maxv, 1};
		send_matrix(e);
		e = '{0, minv, minv, minv, 0, minv, minv, minv, 1};
		send_matrix(e);
		e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_matrix(e);
		pause_sender(1);
	endtask

	task automatic test_random();
		logic signed [IN_W-1:0] e[9];
		int mode;
		for (int n = 0; n < 1500; n++) begin
			mode = $urandom_range(0, 3);
			foreach (e[i])
				e[i] = random_elem(mode % 3);
			// mode 3: one random diagonal element is set between 30000 and 65536
			if (mode == 3) begin
				e[$urandom_range(0, 2) * 4] = IN_W'($urandom_range(30000, 65536));
			end
			send_matrix(e);
			random_gap();
		end
		pause_sender(1);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			pop_mode <= $urandom_range(0, 3);
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 1) == 0);
			2: pop <= ($urandom_range(0, 7) == 0);
			default: pop <= ($urandom_range(0, 15) != 0);
		endcase
	end

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && pop && !empty) begin
			if (expected_quats.size() == 0) begin
				$display("unexpected item at %0t", $realtime);
				mismatches++;
			end else begin
				want = expected_quats.pop_front();
				if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
				if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
				if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
				if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
				if (root_error !== want.err)
					report_mismatch("root_error", root_error, want.err);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		pop_mode = 0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		while (expected_quats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
hdl/rmq_pkg.sv
hdl/rmq_fifo.sv
hdl/rmq_front.sv
hdl/rmq_back.sv
hdl/rotation_matrix_to_quaternion.sv
hdl/rmq_chk.sv
tb/tb_top.sv
